// File: rtl/spvc_pkg.sv
// shared types and constants for the square path velocity command unit
// no dependencies; used by the top level, front, divider stage and back end
package spvc_pkg;

    localparam int RW         = 34;  // rotation entry, signed, Q28 scale
    localparam int EW         = 35;  // target, error and feed-forward width
    localparam int DIV_BITS   = 27;  // distance in whole metres
    localparam int DIV_STEPS  = 3;   // quotient bits per divider stage
    localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;
    localparam int MILLI_BITS = 10;  // 1/1024 fraction of the distance

    localparam logic signed [RW-1:0] ONE_Q28 = 34'sh0_1000_0000;

    typedef logic [2:0][2:0][RW-1:0] rot_t;

    typedef struct packed {
        logic [DIV_BITS-1:0]   num;
        logic [6:0]            rem;
        logic [1:0]            quo;
        logic [MILLI_BITS-1:0] frac;
    } div_t;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        rot_t        rot;
    } geo_t;

    typedef enum logic [1:0] {
        REG_HOVER_ALT,
        REG_SIDE_LENGTH,
        REG_PATH_SPEED,
        REG_GAIN
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SIDE_BOTTOM,
        SIDE_RIGHT,
        SIDE_TOP,
        SIDE_LEFT
    } side_t;

endpackage

// File: rtl/square_path_velocity_command_unit.sv
// square path velocity command unit: top level, config registers, output skid
// pipeline: 3 front, 9 divider and 8 back-end stages, then the output register;
// throughput: one transaction per cycle while the skid entry is empty,
// set by the fully pipelined divider and multipliers
// reset: synchronous active-low aresetn clears all valid bits, loads register defaults
// depends on spvc_pkg, spvc_front, spvc_div_stage, spvc_back
module square_path_velocity_command_unit #(
    parameter int POS_FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // from bit 0: elapsed_time, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z
    input  logic [191:0] s_tdata,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // from bit 0: cmd_vx, cmd_vy, cmd_vz
    output logic [95:0]  m_tdata,
    // register writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int NS = spvc_pkg::DIV_STAGES;

    logic [6:0]  hover_alt_reg;
    logic [6:0]  side_length_reg;
    logic [4:0]  path_speed_reg;
    logic [15:0] gain_q16_reg;
    logic [6:0]  side_eff;

    // whole pipeline advances together unless the skid stage is holding
    logic en;

    logic           dv  [NS+1];
    spvc_pkg::div_t dd  [NS+1];
    spvc_pkg::geo_t dg  [NS+1];

    logic             back_valid;
    logic [2:0][31:0] back_cmd;

    logic        out_valid_reg, out_valid_next;
    logic [95:0] out_data_reg, out_data_next;
    logic        skid_valid_reg, skid_valid_next;
    logic [95:0] skid_data_reg, skid_data_next;
    logic [95:0] back_data;

    assign cfg_ready = 1'b1;
    assign s_tready  = en;
    assign en        = !skid_valid_reg;
    // a zero side is taken as one metre
    assign side_eff  = (side_length_reg == 7'd0) ? 7'd1 : side_length_reg;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hover_alt_reg   <= 7'd3;
            side_length_reg <= 7'd4;
            path_speed_reg  <= 5'd4;
            gain_q16_reg    <= 16'd6554;
        end else if (cfg_valid && cfg_ready) begin
            case (spvc_pkg::cfg_reg_t'(cfg_index))
                spvc_pkg::REG_HOVER_ALT:   hover_alt_reg   <= cfg_data[6:0];
                spvc_pkg::REG_SIDE_LENGTH: side_length_reg <= cfg_data[6:0];
                spvc_pkg::REG_PATH_SPEED:  path_speed_reg  <= cfg_data[4:0];
                spvc_pkg::REG_GAIN:        gain_q16_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // distance and rotation matrix
    spvc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (s_tvalid),
        .elapsed_time (s_tdata[31:0]),
        .pos_x        (s_tdata[63:32]),
        .pos_y        (s_tdata[95:64]),
        .pos_z        (s_tdata[127:96]),
        .quat_w       (s_tdata[143:128]),
        .quat_x       (s_tdata[159:144]),
        .quat_y       (s_tdata[175:160]),
        .quat_z       (s_tdata[191:176]),
        .path_speed   (path_speed_reg),
        .out_valid    (dv[0]),
        .out_div      (dd[0]),
        .out_geo      (dg[0])
    );

    // side index and offset, a few quotient bits per stage
    for (genvar k = 0; k < NS; k++) begin : g_div
        spvc_div_stage u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .side      (side_eff),
            .in_valid  (dv[k]),
            .in_div    (dd[k]),
            .in_geo    (dg[k]),
            .out_valid (dv[k+1]),
            .out_div   (dd[k+1]),
            .out_geo   (dg[k+1])
        );
    end

    // target, gain and body-frame rotation
    spvc_back #(
        .POS_FRAC_BITS (POS_FRAC_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (dv[NS]),
        .in_div        (dd[NS]),
        .in_geo        (dg[NS]),
        .side          (side_eff),
        .hover_alt     (hover_alt_reg),
        .path_speed    (path_speed_reg),
        .gain_q16      (gain_q16_reg),
        .out_valid     (back_valid),
        .cmd           (back_cmd)
    );

    assign back_data = {back_cmd[2], back_cmd[1], back_cmd[0]};

    // output register with one skid entry; input is blocked only once the skid entry holds a result
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (back_valid) begin
            if (out_valid_reg && !m_tready) begin
                skid_data_next  = back_data;
                skid_valid_next = 1'b1;
            end else begin
                out_data_next  = back_data;
                out_valid_next = 1'b1;
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: rtl/spvc_front.sv
// input register, distance and quaternion products, rotation matrix
// depends on spvc_pkg
module spvc_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [31:0]        elapsed_time,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic [4:0]         path_speed,
    output logic               out_valid,
    output spvc_pkg::div_t     out_div,
    output spvc_pkg::geo_t     out_geo
);

    logic               v1_reg, v2_reg, v3_reg;
    logic [31:0]        t1_reg;
    logic [31:0]        px1_reg, py1_reg, pz1_reg;
    logic signed [15:0] qw1_reg, qx1_reg, qy1_reg, qz1_reg;
    logic [36:0]        d2_reg;
    logic [31:0]        px2_reg, py2_reg, pz2_reg;
    logic signed [31:0] pxx_reg, pyy_reg, pzz_reg, pxy_reg, pzw_reg;
    logic signed [31:0] pxz_reg, pyw_reg, pyz_reg, pxw_reg;
    spvc_pkg::div_t     div3_reg;
    spvc_pkg::geo_t     geo3_reg;
    spvc_pkg::rot_t     rot_next;
    logic signed [spvc_pkg::RW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

    always_comb begin
        r00 = spvc_pkg::ONE_Q28 - ((34'(pyy_reg) + 34'(pzz_reg)) <<< 1);
        r01 = (34'(pxy_reg) - 34'(pzw_reg)) <<< 1;
        r02 = (34'(pxz_reg) + 34'(pyw_reg)) <<< 1;
        r10 = (34'(pxy_reg) + 34'(pzw_reg)) <<< 1;
        r11 = spvc_pkg::ONE_Q28 - ((34'(pxx_reg) + 34'(pzz_reg)) <<< 1);
        r12 = (34'(pyz_reg) - 34'(pxw_reg)) <<< 1;
        r20 = (34'(pxz_reg) - 34'(pyw_reg)) <<< 1;
        r21 = (34'(pyz_reg) + 34'(pxw_reg)) <<< 1;
        r22 = spvc_pkg::ONE_Q28 - ((34'(pxx_reg) + 34'(pyy_reg)) <<< 1);
        rot_next[0][0] = r00;
        rot_next[0][1] = r01;
        rot_next[0][2] = r02;
        rot_next[1][0] = r10;
        rot_next[1][1] = r11;
        rot_next[1][2] = r12;
        rot_next[2][0] = r20;
        rot_next[2][1] = r21;
        rot_next[2][2] = r22;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg  <= elapsed_time;
            px1_reg <= pos_x;
            py1_reg <= pos_y;
            pz1_reg <= pos_z;
            qw1_reg <= quat_w;
            qx1_reg <= quat_x;
            qy1_reg <= quat_y;
            qz1_reg <= quat_z;

            d2_reg  <= 37'(t1_reg) * 37'(path_speed);
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
            pz2_reg <= pz1_reg;
            pxx_reg <= qx1_reg * qx1_reg;
            pyy_reg <= qy1_reg * qy1_reg;
            pzz_reg <= qz1_reg * qz1_reg;
            pxy_reg <= qx1_reg * qy1_reg;
            pzw_reg <= qz1_reg * qw1_reg;
            pxz_reg <= qx1_reg * qz1_reg;
            pyw_reg <= qy1_reg * qw1_reg;
            pyz_reg <= qy1_reg * qz1_reg;
            pxw_reg <= qx1_reg * qw1_reg;

            div3_reg.num  <= d2_reg[36:spvc_pkg::MILLI_BITS];
            div3_reg.rem  <= 7'd0;
            div3_reg.quo  <= 2'd0;
            div3_reg.frac <= d2_reg[spvc_pkg::MILLI_BITS-1:0];
            geo3_reg.pos_x <= px2_reg;
            geo3_reg.pos_y <= py2_reg;
            geo3_reg.pos_z <= pz2_reg;
            geo3_reg.rot   <= rot_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_div   = div3_reg;
    assign out_geo   = geo3_reg;

endmodule

// File: rtl/spvc_div_stage.sv
// one stage of the restoring divider: distance in metres by side length
// depends on spvc_pkg
module spvc_div_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic [6:0]     side,
    input  logic           in_valid,
    input  spvc_pkg::div_t in_div,
    input  spvc_pkg::geo_t in_geo,
    output logic           out_valid,
    output spvc_pkg::div_t out_div,
    output spvc_pkg::geo_t out_geo
);

    logic           valid_reg;
    spvc_pkg::div_t div_reg;
    spvc_pkg::geo_t geo_reg;
    spvc_pkg::div_t div_next;

    always_comb begin
        logic [7:0] trial;
        logic       ge;
        div_next = in_div;
        for (int k = 0; k < spvc_pkg::DIV_STEPS; k++) begin
            trial = {div_next.rem, div_next.num[spvc_pkg::DIV_BITS-1]};
            ge    = (trial >= {1'b0, side});
            div_next.rem = ge ? 7'(trial - {1'b0, side}) : trial[6:0];
            div_next.quo = {div_next.quo[0], ge};
            div_next.num = {div_next.num[spvc_pkg::DIV_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg <= div_next;
            geo_reg <= in_geo;
        end
    end

    assign out_valid = valid_reg;
    assign out_div   = div_reg;
    assign out_geo   = geo_reg;

endmodule

// File: rtl/spvc_back.sv
// target selection, gain term, body-frame rotation and saturation
// depends on spvc_pkg
module spvc_back #(
    parameter int POS_FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  spvc_pkg::div_t    in_div,
    input  spvc_pkg::geo_t    in_geo,
    input  logic [6:0]        side,
    input  logic [6:0]        hover_alt,
    input  logic [4:0]        path_speed,
    input  logic [15:0]       gain_q16,
    output logic              out_valid,
    output logic [2:0][31:0]  cmd
);

    localparam int EW  = spvc_pkg::EW;
    localparam int RW  = spvc_pkg::RW;
    localparam int SHL = (POS_FRAC_BITS >= spvc_pkg::MILLI_BITS) ?
                         POS_FRAC_BITS - spvc_pkg::MILLI_BITS : 0;
    localparam int SHR = (POS_FRAC_BITS >= spvc_pkg::MILLI_BITS) ?
                         0 : spvc_pkg::MILLI_BITS - POS_FRAC_BITS;
    localparam int PRW = EW + 17;
    localparam int CW  = PRW - 15;
    localparam int HW  = CW - 14;
    localparam int PHW = RW + HW;
    localparam int PLW = RW + 15;
    localparam int AHW = PHW + 2;
    localparam int ALW = PLW + 2;
    localparam int BW  = AHW + 1 - 14;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;

    logic signed [EW-1:0]  tgt_reg [3];
    logic signed [EW-1:0]  ff1_reg [3];
    spvc_pkg::geo_t        geo1_reg;
    logic signed [EW-1:0]  err_reg [3];
    logic signed [EW-1:0]  ff2_reg [3];
    spvc_pkg::rot_t        rot2_reg;
    logic signed [PRW-1:0] prod_reg [3];
    logic signed [EW-1:0]  ff3_reg [3];
    spvc_pkg::rot_t        rot3_reg;
    logic signed [CW-1:0]  c_reg [3];
    spvc_pkg::rot_t        rot4_reg;
    logic signed [PHW-1:0] ph_reg [3][3];
    logic signed [PLW-1:0] pl_reg [3][3];
    logic signed [AHW-1:0] acc_hi_reg [3];
    logic signed [ALW-1:0] acc_lo_reg [3];
    logic signed [BW-1:0]  body_reg [3];
    logic [2:0][31:0]      cmd_reg;

    logic signed [EW-1:0]  tgt_next [3];
    logic signed [EW-1:0]  ff_next [3];
    logic signed [EW-1:0]  pos_ext [3];

    always_comb begin
        logic [16:0]          l_milli;
        logic signed [EW-1:0] lp, lenp, half, sp;
        l_milli = {in_div.rem, in_div.frac};
        lp   = EW'((EW'(l_milli) << SHL) >> SHR);
        lenp = EW'(EW'(side) << POS_FRAC_BITS);
        half = EW'(EW'(side[6:1]) << POS_FRAC_BITS);
        sp   = EW'(EW'(path_speed) << POS_FRAC_BITS);
        case (spvc_pkg::side_t'(in_div.quo))
            spvc_pkg::SIDE_BOTTOM: begin
                tgt_next[0] = lp;
                tgt_next[1] = '0;
                ff_next[0]  = sp;
                ff_next[1]  = '0;
            end
            spvc_pkg::SIDE_RIGHT: begin
                tgt_next[0] = lenp;
                tgt_next[1] = lp;
                ff_next[0]  = '0;
                ff_next[1]  = sp;
            end
            spvc_pkg::SIDE_TOP: begin
                tgt_next[0] = lenp - lp;
                tgt_next[1] = lenp;
                ff_next[0]  = -sp;
                ff_next[1]  = '0;
            end
            default: begin
                tgt_next[0] = '0;
                tgt_next[1] = lenp - lp;
                ff_next[0]  = '0;
                ff_next[1]  = -sp;
            end
        endcase
        tgt_next[0] = tgt_next[0] - half;
        tgt_next[1] = tgt_next[1] - half;
        tgt_next[2] = EW'(EW'(hover_alt) << POS_FRAC_BITS);
        ff_next[2]  = '0;
    end

    assign pos_ext[0] = EW'($signed(geo1_reg.pos_x));
    assign pos_ext[1] = EW'($signed(geo1_reg.pos_y));
    assign pos_ext[2] = EW'($signed(geo1_reg.pos_z));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            geo1_reg <= in_geo;
            rot2_reg <= geo1_reg.rot;
            rot3_reg <= rot2_reg;
            rot4_reg <= rot3_reg;
            for (int i = 0; i < 3; i++) begin
                tgt_reg[i]  <= tgt_next[i];
                ff1_reg[i]  <= ff_next[i];
                err_reg[i]  <= tgt_reg[i] - pos_ext[i];
                ff2_reg[i]  <= ff1_reg[i];
                prod_reg[i] <= $signed({1'b0, gain_q16}) * err_reg[i] + PRW'(32768);
                ff3_reg[i]  <= ff2_reg[i];
                c_reg[i]    <= CW'(prod_reg[i] >>> 16) + CW'(ff3_reg[i]);
                // split the command so each product stays narrow
                for (int j = 0; j < 3; j++) begin
                    ph_reg[j][i] <= $signed(rot4_reg[j][i]) * $signed(c_reg[j][CW-1:14]);
                    pl_reg[j][i] <= $signed(rot4_reg[j][i]) * $signed({1'b0, c_reg[j][13:0]});
                end
                acc_hi_reg[i] <= AHW'(ph_reg[0][i]) + AHW'(ph_reg[1][i]) + AHW'(ph_reg[2][i]);
                acc_lo_reg[i] <= ALW'(pl_reg[0][i]) + ALW'(pl_reg[1][i])
                               + ALW'(pl_reg[2][i]) + ALW'(1 << 27);
                body_reg[i] <= BW'((AHW'(acc_hi_reg[i]) + AHW'(acc_lo_reg[i] >>> 14)) >>> 14);
                if (body_reg[i][BW-1:31] != {(BW-31){body_reg[i][31]}}) begin
                    cmd_reg[i] <= body_reg[i][BW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
                end else begin
                    cmd_reg[i] <= body_reg[i][31:0];
                end
            end
        end
    end

    assign out_valid = v8_reg;
    assign cmd       = cmd_reg;

endmodule

// File: rtl/spvc_checker.sv
// port-level checks for the square path velocity command unit, with bind
// depends on square_path_velocity_command_unit
module spvc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [95:0]  m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // input only backs off while a result is waiting
    a_ready_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // input backs off only after an output stall
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

endmodule

bind square_path_velocity_command_unit spvc_checker u_spvc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
